FILE: hdl/nlp_pkg.sv
package nlp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TAP_W      = 24;
   localparam int ERR_W      = 17;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int THR_W      = 15;
   localparam int SHIFT_W    = 4;

   // window magnitude sum, four roots of at most 46341
   localparam int TOT_W      = 18;
   // square root unit: radicand and root
   localparam int RAD_SQ_W   = 34;
   localparam int ROOT_W     = 17;
   localparam int SQ_CNT_W   = 5;
   // divider: rounded magnitude of the scaled correlation
   localparam int NUM_W      = 48;
   localparam int DIV_CNT_W  = 6;

   localparam logic [KIND_W-1:0] KIND_PASS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GATED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRED  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TAP_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_SHIFT = 3'd5;

   localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd3277;
   localparam logic [SHIFT_W-1:0] SHIFT_RST     = 4'd5;
   localparam logic [ERR_W-1:0]   ERR_MAX       = 17'h1FFFF;

   localparam logic signed [TAP_W-1:0] INIT_TAP_RST [4] = '{
      24'sd1048576, 24'sd0, 24'sd0, 24'sd0
   };

   typedef struct packed {
      logic signed [TAP_W-1:0] re;
      logic signed [TAP_W-1:0] im;
   } tap_type;

   typedef struct packed {
      logic                    rotate;
      logic                    load;
      logic signed [TAP_W-1:0] load_re;
   } tap_ctl_type;

endpackage

FILE: hdl/nlp_tap_cell.sv
module nlp_tap_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [nlp_pkg::TAP_W-1:0]    rst_re,
   input  nlp_pkg::tap_ctl_type                ctl,
   input  nlp_pkg::tap_type                    nbr,
   output nlp_pkg::tap_type                    tap
);

   nlp_pkg::tap_type tap_ff, tap_in;

   always_comb begin
      tap_in = tap_ff;
      if (ctl.load) begin
         tap_in.re = ctl.load_re;
         tap_in.im = '0;
      end else if (ctl.rotate) begin
         // advance one place toward the head of the ring
         tap_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff.re <= rst_re;
         tap_ff.im <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign tap = tap_ff;

endmodule

FILE: hdl/nlp_sqrt.sv
module nlp_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [nlp_pkg::RAD_SQ_W-1:0]     radicand,
   output logic                             done,
   output logic [nlp_pkg::ROOT_W-1:0]       root
);

   localparam int REM_W = nlp_pkg::ROOT_W + 3;

   logic [nlp_pkg::RAD_SQ_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [nlp_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [nlp_pkg::SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [REM_W-1:0]             rem_t, trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_t   = {rem_ff[REM_W-3:0], rad_ff[nlp_pkg::RAD_SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = nlp_pkg::SQ_CNT_W'(nlp_pkg::ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one root bit per cycle
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_ff[nlp_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_ff[nlp_pkg::ROOT_W-2:0], 1'b0};
         end
         rad_in = {rad_ff[nlp_pkg::RAD_SQ_W-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: hdl/nlp_div.sv
module nlp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [nlp_pkg::NUM_W-1:0]       num,
   input  logic [nlp_pkg::TOT_W-1:0]       den,
   output logic                            done,
   output logic [nlp_pkg::NUM_W-1:0]       quo
);

   localparam int REM_W = nlp_pkg::TOT_W + 1;

   logic [nlp_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [nlp_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [nlp_pkg::TOT_W-1:0]     den_ff, den_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [nlp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [REM_W-1:0]              rem_t;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_t   = {rem_ff[REM_W-2:0], num_ff[nlp_pkg::NUM_W-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = nlp_pkg::DIV_CNT_W'(nlp_pkg::NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring division, one quotient bit per cycle
         if (rem_t >= {1'b0, den_ff}) begin
            rem_in = rem_t - {1'b0, den_ff};
            quo_in = {quo_ff[nlp_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_t;
            quo_in = {quo_ff[nlp_pkg::NUM_W-2:0], 1'b0};
         end
         num_in = {num_ff[nlp_pkg::NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: hdl/normalized_lms_linear_predictor_core.sv
// Adaptive complex linear predictor, normalized LMS, fixed point.
// Input channel req_*: one complex Q1.15 sample word per accept
// (req_valid high, req_stall low). Result channel rsp_*: one word per
// handled index n-PREDICT_DISTANCE, taken when rsp_valid is high and
// rsp_stall low. Words from the first PREDICT_DISTANCE samples give no result.
// Config channel csr_*: always ready; write it only while the block is idle.
// Writing an init tap register loads that tap directly (imaginary part zero).
// The block works on one sample at a time; req_stall is high while it does.
// Handling time depends on the mode: filling, passthrough, gated or
// predicting, and a prediction is shorter when the error magnitude
// saturates, as the root unit is then skipped. The bit-serial divider
// dominates prediction: two divisions per tap.
// A bit-serial root unit serves the window magnitudes and the error
// magnitude; taps sit in a ring of cells that rotates one place per tap
// step past a single shared multiplier.
// The result word loads into an output register at the edge at which
// req_stall drops, so a stalled receiver holds the word while the next
// sample is taken and worked on; the next result waits until it is taken.
// Reset (synchronous) clears history, counters and smoothing, restores
// register defaults and reloads the taps from them.
module normalized_lms_linear_predictor_core #(
   parameter int NUM_TAPS         = 4,
   parameter int PREDICT_DISTANCE = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [nlp_pkg::SAMPLE_W-1:0]   req_sample_re,
   input  logic signed [nlp_pkg::SAMPLE_W-1:0]   req_sample_im,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [nlp_pkg::SAMPLE_W-1:0]   rsp_out_re,
   output logic signed [nlp_pkg::SAMPLE_W-1:0]   rsp_out_im,
   output logic [nlp_pkg::KIND_W-1:0]            rsp_out_kind,
   output logic [nlp_pkg::ERR_W-1:0]             rsp_error_level,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nlp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nlp_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int HIST_DEPTH = PREDICT_DISTANCE + NUM_TAPS;
   localparam int WC_W       = $clog2(HIST_DEPTH);
   localparam int KW         = $clog2(NUM_TAPS);
   localparam int SW         = nlp_pkg::SAMPLE_W;
   localparam int TW         = nlp_pkg::TAP_W;
   localparam int MUL_W      = TW + 1;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = TW + SW + 4;
   localparam int E_W        = TW + 1;
   localparam int PACC_W     = E_W + SW + 1;
   localparam int SCL_W      = PACC_W + 5;
   localparam int RAD_W      = PROD_W + 1;
   localparam int SAT_W      = nlp_pkg::NUM_W + 2;
   localparam int SM_W       = nlp_pkg::ERR_W + 3;

   localparam logic [WC_W-1:0] WC_MAX = WC_W'(HIST_DEPTH - 1);
   localparam logic [WC_W-1:0] PD_V   = WC_W'(PREDICT_DISTANCE);
   localparam logic [KW-1:0]   K_LAST = KW'(NUM_TAPS - 1);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_DECIDE = 14'b00000000000010,
      S_MAG    = 14'b00000000000100,
      S_MROOT  = 14'b00000000001000,
      S_GATE   = 14'b00000000010000,
      S_MAC    = 14'b00000000100000,
      S_PRED   = 14'b00000001000000,
      S_EMAG   = 14'b00000010000000,
      S_EROOT  = 14'b00000100000000,
      S_SMOOTH = 14'b00001000000000,
      S_UPD    = 14'b00010000000000,
      S_DRE    = 14'b00100000000000,
      S_DIM    = 14'b01000000000000,
      S_EMIT   = 14'b10000000000000
   } state_type;

   function automatic logic signed [SW-1:0] sat_out(input logic signed [TW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > TW'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -TW'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TW-1:0] tap_add(input logic signed [TW-1:0] old,
                                                    input logic neg,
                                                    input logic [nlp_pkg::NUM_W-1:0] q);
      logic signed [SAT_W-1:0] qs;
      logic signed [SAT_W-1:0] s;
      logic signed [TW-1:0]    r;
      qs = $signed({2'b00, q});
      s  = SAT_W'(old) + (neg ? -qs : qs);
      if (s > SAT_W'(8388607)) begin
         r = 24'sh7FFFFF;
      end else if (s < -SAT_W'(8388608)) begin
         r = 24'sh800000;
      end else begin
         r = s[TW-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic signed [SW-1:0] hist_re_ff [HIST_DEPTH];
   logic signed [SW-1:0] hist_im_ff [HIST_DEPTH];
   logic signed [SW-1:0] win_re [NUM_TAPS];
   logic signed [SW-1:0] win_im [NUM_TAPS];

   logic [WC_W-1:0] warm_ff, warm_in, n_ff, n_in;
   logic [nlp_pkg::THR_W-1:0]   thr_ff;
   logic [nlp_pkg::SHIFT_W-1:0] shift_ff;
   logic [2:0]      ph_ff, ph_in;
   logic [KW-1:0]   k_ff, k_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_ff;
   logic [RAD_W-1:0]         rad_ff, rad_in, rad_sum;
   logic [nlp_pkg::TOT_W-1:0] tot_ff, tot_in, thr_nt;
   logic signed [ACC_W-1:0]  accre_ff, accre_in, accim_ff, accim_in, yre_sum, yim_sum;
   logic signed [ACC_W-1:0]  prod_acc;
   logic signed [TW-1:0]     yre_c, yim_c;
   logic signed [E_W-1:0]    ere_ff, ere_in, eim_ff, eim_in;
   logic [nlp_pkg::ERR_W-1:0] ne_ff, ne_in, avg_ff, avg_in;
   logic                     seen_ff, seen_in;
   logic signed [SM_W-1:0]   sm_diff, sm_rnd, sm_sum;
   logic [nlp_pkg::ERR_W-1:0] sm_new;
   logic signed [PACC_W-1:0] pre_ff, pre_in, pim_ff, pim_in, prod_p, dv_p;
   logic signed [SCL_W-1:0]  dv_scaled;
   logic [SCL_W-1:0]         dv_mag;
   logic [nlp_pkg::NUM_W-1:0] dv_num, dv_quo;
   logic                     dv_start, dv_done;
   logic signed [TW-1:0]     nre_ff, nre_in;
   logic signed [SW-1:0]     res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic [nlp_pkg::KIND_W-1:0] res_kind_ff, res_kind_in;
   logic                     sq_start, sq_done;
   logic [nlp_pkg::RAD_SQ_W-1:0] sq_rad;
   logic [nlp_pkg::ROOT_W-1:0]   sq_root;
   logic                     tap_rot, tap_wb, emit_load;
   logic                     accept, csr_wr;

   nlp_pkg::tap_type     tap_q   [NUM_TAPS];
   nlp_pkg::tap_type     tap_nbr [NUM_TAPS];
   nlp_pkg::tap_ctl_type tap_ctl [NUM_TAPS];
   nlp_pkg::tap_type     tail_src;

   logic                     rsp_valid_ff;
   logic signed [SW-1:0]     rsp_re_ff, rsp_im_ff;
   logic [nlp_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [nlp_pkg::ERR_W-1:0]  rsp_err_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // prediction window x[i-k] sits at fixed places of the history line
   for (genvar j = 0; j < NUM_TAPS; j++) begin : g_win
      assign win_re[j] = hist_re_ff[PREDICT_DISTANCE + j];
      assign win_im[j] = hist_im_ff[PREDICT_DISTANCE + j];
   end

   // tap ring: during the tap steps the head cell holds tap k
   assign tail_src = tap_wb ? nlp_pkg::tap_type'{re: nre_ff,
                                                 im: tap_add(tap_q[0].im, pim_ff[PACC_W-1],
                                                             dv_quo)}
                            : tap_q[0];

   for (genvar j = 0; j < NUM_TAPS; j++) begin : g_tap
      if (j == NUM_TAPS - 1) begin : g_tail
         assign tap_nbr[j] = tail_src;
      end else begin : g_body
         assign tap_nbr[j] = tap_q[j+1];
      end
      assign tap_ctl[j].rotate  = tap_rot;
      assign tap_ctl[j].load    = csr_wr && (csr_index == nlp_pkg::CSR_IDX_W'(j));
      assign tap_ctl[j].load_re = $signed(csr_data);

      nlp_tap_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .rst_re (nlp_pkg::INIT_TAP_RST[j]),
         .ctl    (tap_ctl[j]),
         .nbr    (tap_nbr[j]),
         .tap    (tap_q[j])
      );
   end

   nlp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   nlp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (tot_ff),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MAG: begin
            mul_a = (ph_ff == 3'd0) ? MUL_W'(win_re[k_ff]) : MUL_W'(win_im[k_ff]);
            mul_b = mul_a;
         end
         S_MAC: begin
            case (ph_ff)
               3'd0: begin mul_a = MUL_W'(tap_q[0].re); mul_b = MUL_W'(win_re[k_ff]); end
               3'd1: begin mul_a = MUL_W'(tap_q[0].im); mul_b = MUL_W'(win_im[k_ff]); end
               3'd2: begin mul_a = MUL_W'(tap_q[0].re); mul_b = MUL_W'(win_im[k_ff]); end
               default: begin mul_a = MUL_W'(tap_q[0].im); mul_b = MUL_W'(win_re[k_ff]); end
            endcase
         end
         S_EMAG: begin
            mul_a = (ph_ff == 3'd0) ? MUL_W'(ere_ff) : MUL_W'(eim_ff);
            mul_b = mul_a;
         end
         S_UPD: begin
            case (ph_ff)
               3'd0: begin mul_a = MUL_W'(ere_ff); mul_b = MUL_W'(win_re[k_ff]); end
               3'd1: begin mul_a = MUL_W'(eim_ff); mul_b = MUL_W'(win_im[k_ff]); end
               3'd2: begin mul_a = MUL_W'(ere_ff); mul_b = MUL_W'(win_im[k_ff]); end
               default: begin mul_a = MUL_W'(eim_ff); mul_b = MUL_W'(win_re[k_ff]); end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // datapath helpers
   always_comb begin
      prod_acc = mul_ff[ACC_W-1:0];
      prod_p   = mul_ff[PACC_W-1:0];
      rad_sum  = rad_ff + RAD_W'($unsigned(mul_ff));
      thr_nt   = nlp_pkg::TOT_W'(thr_ff) * nlp_pkg::TOT_W'(NUM_TAPS);

      // round half up to Q.15
      yre_sum  = accre_ff + ACC_W'(524288);
      yim_sum  = accim_ff + ACC_W'(524288);
      yre_c    = yre_sum[ACC_W-1:20];
      yim_c    = yim_sum[ACC_W-1:20];

      sm_diff  = $signed({3'b000, ne_ff}) - $signed({3'b000, avg_ff});
      if (shift_ff == '0) begin
         sm_rnd = sm_diff;
      end else begin
         sm_rnd = (sm_diff + (SM_W'(1) <<< (shift_ff - 1'b1))) >>> shift_ff;
      end
      sm_sum = $signed({3'b000, avg_ff}) + sm_rnd;
      if (sm_sum < 0) begin
         sm_new = '0;
      end else if (sm_sum > $signed({3'b000, nlp_pkg::ERR_MAX})) begin
         sm_new = nlp_pkg::ERR_MAX;
      end else begin
         sm_new = sm_sum[nlp_pkg::ERR_W-1:0];
      end

      // |p*32| plus half the divisor gives round-to-nearest, ties away
      dv_p      = (state_ff == S_DRE) ? pim_ff : pre_ff;
      dv_scaled = $signed({dv_p, 5'b00000});
      dv_mag    = dv_scaled[SCL_W-1] ? SCL_W'(-dv_scaled) : SCL_W'(dv_scaled);
      dv_num    = {1'b0, dv_mag} + nlp_pkg::NUM_W'(tot_ff >> 1);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      warm_in     = warm_ff;
      n_in        = n_ff;
      ph_in       = ph_ff;
      k_in        = k_ff;
      rad_in      = rad_ff;
      tot_in      = tot_ff;
      accre_in    = accre_ff;
      accim_in    = accim_ff;
      ere_in      = ere_ff;
      eim_in      = eim_ff;
      ne_in       = ne_ff;
      avg_in      = avg_ff;
      seen_in     = seen_ff;
      pre_in      = pre_ff;
      pim_in      = pim_ff;
      nre_in      = nre_ff;
      res_re_in   = res_re_ff;
      res_im_in   = res_im_ff;
      res_kind_in = res_kind_ff;
      sq_start    = 1'b0;
      sq_rad      = rad_sum[nlp_pkg::RAD_SQ_W-1:0];
      dv_start    = 1'b0;
      tap_rot     = 1'b0;
      tap_wb      = 1'b0;
      emit_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in = warm_ff;
               if (warm_ff < WC_MAX) begin
                  warm_in = warm_ff + 1'b1;
               end
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (n_ff < PD_V) begin
               state_in = S_IDLE;
            end else if (n_ff < WC_MAX) begin
               res_re_in   = hist_re_ff[PREDICT_DISTANCE];
               res_im_in   = hist_im_ff[PREDICT_DISTANCE];
               res_kind_in = nlp_pkg::KIND_PASS;
               state_in    = S_EMIT;
            end else begin
               tot_in   = '0;
               k_in     = '0;
               ph_in    = '0;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  rad_in = RAD_W'($unsigned(mul_ff));
                  ph_in  = 3'd2;
               end
               default: begin
                  sq_start = 1'b1;
                  ph_in    = '0;
                  state_in = S_MROOT;
               end
            endcase
         end
         S_MROOT: begin
            if (sq_done) begin
               tot_in = tot_ff + nlp_pkg::TOT_W'(sq_root);
               if (k_ff == K_LAST) begin
                  k_in     = '0;
                  state_in = S_GATE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_MAG;
               end
            end
         end
         S_GATE: begin
            if (tot_ff == '0 || tot_ff < thr_nt) begin
               res_re_in   = '0;
               res_im_in   = '0;
               res_kind_in = nlp_pkg::KIND_GATED;
               state_in    = S_EMIT;
            end else begin
               accre_in = '0;
               accim_in = '0;
               k_in     = '0;
               ph_in    = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin accre_in = accre_ff + prod_acc; ph_in = 3'd2; end
               3'd2: begin accre_in = accre_ff + prod_acc; ph_in = 3'd3; end
               3'd3: begin accim_in = accim_ff + prod_acc; ph_in = 3'd4; end
               default: begin
                  accim_in = accim_ff - prod_acc;
                  tap_rot  = 1'b1;
                  ph_in    = '0;
                  if (k_ff == K_LAST) begin
                     k_in     = '0;
                     state_in = S_PRED;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end
         S_PRED: begin
            ere_in      = E_W'(hist_re_ff[0]) - E_W'(yre_c);
            eim_in      = E_W'(hist_im_ff[0]) - E_W'(yim_c);
            res_re_in   = sat_out(yre_c);
            res_im_in   = sat_out(yim_c);
            res_kind_in = nlp_pkg::KIND_PRED;
            ph_in       = '0;
            state_in    = S_EMAG;
         end
         S_EMAG: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  rad_in = RAD_W'($unsigned(mul_ff));
                  ph_in  = 3'd2;
               end
               default: begin
                  ph_in = '0;
                  // a root beyond 17 bits saturates, so skip the unit
                  if (rad_sum[RAD_W-1:nlp_pkg::RAD_SQ_W] != '0) begin
                     ne_in    = nlp_pkg::ERR_MAX;
                     state_in = S_SMOOTH;
                  end else begin
                     sq_start = 1'b1;
                     state_in = S_EROOT;
                  end
               end
            endcase
         end
         S_EROOT: begin
            if (sq_done) begin
               ne_in    = sq_root;
               state_in = S_SMOOTH;
            end
         end
         S_SMOOTH: begin
            if (!seen_ff) begin
               avg_in  = ne_ff;
               seen_in = 1'b1;
            end else begin
               avg_in = sm_new;
            end
            k_in     = '0;
            ph_in    = '0;
            state_in = S_UPD;
         end
         S_UPD: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin pre_in = prod_p; ph_in = 3'd2; end
               3'd2: begin pre_in = pre_ff + prod_p; ph_in = 3'd3; end
               3'd3: begin pim_in = prod_p; ph_in = 3'd4; end
               default: begin
                  pim_in   = pim_ff - prod_p;
                  dv_start = 1'b1;
                  ph_in    = '0;
                  state_in = S_DRE;
               end
            endcase
         end
         S_DRE: begin
            if (dv_done) begin
               nre_in   = tap_add(tap_q[0].re, pre_ff[PACC_W-1], dv_quo);
               dv_start = 1'b1;
               state_in = S_DIM;
            end
         end
         S_DIM: begin
            if (dv_done) begin
               // write the updated tap back through the tail
               tap_rot = 1'b1;
               tap_wb  = 1'b1;
               if (k_ff == K_LAST) begin
                  k_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_UPD;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_load = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rad_ff      <= rad_in;
      tot_ff      <= tot_in;
      accre_ff    <= accre_in;
      accim_ff    <= accim_in;
      ere_ff      <= ere_in;
      eim_ff      <= eim_in;
      ne_ff       <= ne_in;
      pre_ff      <= pre_in;
      pim_ff      <= pim_in;
      nre_ff      <= nre_in;
      res_re_ff   <= res_re_in;
      res_im_ff   <= res_im_in;
      res_kind_ff <= res_kind_in;
      n_ff        <= n_in;
      if (reset) begin
         state_ff <= S_IDLE;
         warm_ff  <= '0;
         ph_ff    <= '0;
         k_ff     <= '0;
         avg_ff   <= '0;
         seen_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         warm_ff  <= warm_in;
         ph_ff    <= ph_in;
         k_ff     <= k_in;
         avg_ff   <= avg_in;
         seen_ff  <= seen_in;
      end
   end

   // history line, shifted on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < HIST_DEPTH; d++) begin
            hist_re_ff[d] <= '0;
            hist_im_ff[d] <= '0;
         end
      end else if (accept) begin
         hist_re_ff[0] <= req_sample_re;
         hist_im_ff[0] <= req_sample_im;
         for (int d = 1; d < HIST_DEPTH; d++) begin
            hist_re_ff[d] <= hist_re_ff[d-1];
            hist_im_ff[d] <= hist_im_ff[d-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= nlp_pkg::THRESHOLD_RST;
         shift_ff <= nlp_pkg::SHIFT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            nlp_pkg::CSR_THRESHOLD:    thr_ff   <= csr_data[nlp_pkg::THR_W-1:0];
            nlp_pkg::CSR_SMOOTH_SHIFT: shift_ff <= csr_data[nlp_pkg::SHIFT_W-1:0];
            default: begin
               // init taps load the ring directly; other codes drop
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_re_ff   <= res_re_ff;
         rsp_im_ff   <= res_im_ff;
         rsp_kind_ff <= res_kind_ff;
         rsp_err_ff  <= avg_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_load || (rsp_valid_ff && rsp_stall);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_re      = rsp_re_ff;
   assign rsp_out_im      = rsp_im_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_error_level = rsp_err_ff;

endmodule

FILE: hdl/nlp_check.sv
module nlp_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [nlp_pkg::SAMPLE_W-1:0]   req_sample_re,
   input logic signed [nlp_pkg::SAMPLE_W-1:0]   req_sample_im,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [nlp_pkg::SAMPLE_W-1:0]   rsp_out_re,
   input logic signed [nlp_pkg::SAMPLE_W-1:0]   rsp_out_im,
   input logic [nlp_pkg::KIND_W-1:0]            rsp_out_kind,
   input logic [nlp_pkg::ERR_W-1:0]             rsp_error_level,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic [nlp_pkg::CSR_IDX_W-1:0]         csr_index,
   input logic [nlp_pkg::CSR_DATA_W-1:0]        csr_data
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_re) && $stable(rsp_out_im)
                                 && $stable(rsp_out_kind) && $stable(rsp_error_level))
      else $error("result word changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the channels");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in work");

   a_gated_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == nlp_pkg::KIND_GATED |-> rsp_out_re == '0 && rsp_out_im == '0)
      else $error("gated word carries a nonzero value");

endmodule

bind normalized_lms_linear_predictor_core nlp_check u_nlp_check (.*);
